FILE: design/knn_incremental_majority_vote_core_assert.svh
// ----------------------------------------------------------------------------
// kNN majority vote assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KNN_INCREMENTAL_MAJORITY_VOTE_CORE_ASSERT_SVH
`define KNN_INCREMENTAL_MAJORITY_VOTE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define KIMV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("kimv assertion failed");

`define KIMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kimv assertion failed");

`else

`define KIMV_ASSERT(lbl, clk, rst_n, prop)

`define KIMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/kimv_pkg.sv
// ----------------------------------------------------------------------------
// kimv_pkg
// Shared types and constants of the kNN incremental majority vote core.
// ----------------------------------------------------------------------------
`default_nettype none

package kimv_pkg;

    localparam int MAX_CLASSES_DEF    = 16;
    localparam int MAX_NEIGHBOURS_DEF = 64;

    localparam int CLS_W      = 4;
    localparam int K_W        = 7;
    localparam int NCLS_W     = 5;
    localparam int LABEL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [K_W-1:0]    K_RST    = 7'd3;
    localparam logic [NCLS_W-1:0] NCLS_RST = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K    = 2'd0,
        CFG_NCLS = 2'd1,
        CFG_OFS  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_store_ctl;

endpackage

`default_nettype wire

FILE: design/kimv_if.sv
// ----------------------------------------------------------------------------
// kimv request channels
// Valid/ready channels for neighbour requests and vote results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kimv_in_if;
    import kimv_pkg::*;

    logic             valid;
    logic             ready;
    logic [CLS_W-1:0] neighbour_class;

    modport source (output valid, output neighbour_class, input ready);
    modport sink   (input valid, input neighbour_class, output ready);
endinterface

interface kimv_out_if;
    import kimv_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LABEL_W-1:0] class_label;
    logic                      last_of_query;
    logic                      class_error;

    modport source (output valid, output class_label, output last_of_query,
                    output class_error, input ready);
    modport sink   (input valid, input class_label, input last_of_query,
                    input class_error, output ready);
endinterface

`default_nettype wire

FILE: design/kimv_count_store.sv
// ----------------------------------------------------------------------------
// kimv_count_store
// Per-class vote count RAM with registered read, write-to-read forwarding and
// per-entry valid flops that clear the whole histogram at once.
// ----------------------------------------------------------------------------
`default_nettype none

module kimv_count_store #(
    parameter int DEPTH  = kimv_pkg::MAX_CLASSES_DEF,
    parameter int DATA_W = $clog2(kimv_pkg::MAX_NEIGHBOURS_DEF + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire kimv_pkg::t_store_ctl       i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [DATA_W-1:0]          i_wr_data,
    output logic      [DATA_W-1:0]          o_count
);
    import kimv_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_fwd_data;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_fwd;
    logic [DEPTH-1:0]  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata    <= r_mem[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd   <= 1'b0;
            r_valid <= '0;
        end else begin
            if (i_ctl.rd_en) begin
                r_fwd <= i_ctl.wr_en && (i_wr_addr == i_rd_addr);
            end
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_count = r_valid[r_rd_addr] ? (r_fwd ? r_fwd_data : r_rdata) : '0;

endmodule

`default_nettype wire

FILE: design/knn_incremental_majority_vote_core.sv
// ----------------------------------------------------------------------------
// knn_incremental_majority_vote_core
// Running k-nearest-neighbour majority vote with lowest-index tie break.
// ----------------------------------------------------------------------------
// Takes one neighbour class per request, nearest first, and returns one result
// per request: the leading class so far plus label_offset, flagged last after
// k neighbours and flagged as error for a class at or above the class count.
// One request is accepted every cycle; a result passes the stage 1 register
// and the output register (count RAM read in the accept cycle, then increment,
// leader compare and write-back with the result registered). A full output
// register stalls the second stage and with it the input. At the end of a
// query the histogram is cleared at once by per-class valid flops, with no pass.
`default_nettype none

module knn_incremental_majority_vote_core #(
    parameter int MAX_CLASSES    = kimv_pkg::MAX_CLASSES_DEF,
    parameter int MAX_NEIGHBOURS = kimv_pkg::MAX_NEIGHBOURS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    kimv_in_if.sink                              i_nb,
    kimv_out_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [kimv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kimv_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kimv_pkg::*;

`include "knn_incremental_majority_vote_core_assert.svh"

    localparam int ADDR_W = $clog2(MAX_CLASSES);
    localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
    localparam int CMP_W  = (ADDR_W + 1 > NCLS_W) ? ADDR_W + 1 : NCLS_W;
    localparam int KCMP_W = (CNT_W > K_W) ? CNT_W : K_W;

    logic [K_W-1:0]     r_k;
    logic [NCLS_W-1:0]  r_ncls;
    logic [LABEL_W-1:0] r_ofs;

    logic               r_s1_vld;
    logic [ADDR_W-1:0]  r_s1_cls;
    logic               r_s1_err;

    logic [CNT_W-1:0]   r_seen;
    logic [ADDR_W-1:0]  r_lead_cls;
    logic [CNT_W-1:0]   r_lead_cnt;

    logic               r_o_vld;
    logic [LABEL_W-1:0] r_o_label;
    logic               r_o_last;
    logic               r_o_err;

    logic [CMP_W-1:0]   eff_cls;
    logic [KCMP_W-1:0]  eff_k;
    logic               in_range;
    logic               acc;
    logic               s1_adv;
    logic [CNT_W-1:0]   old_cnt;
    logic [CNT_W-1:0]   cnt_new;
    logic               take;
    logic [ADDR_W-1:0]  n_lead_cls;
    logic [CNT_W-1:0]   n_lead_cnt;
    logic [CNT_W-1:0]   n_seen;
    logic               last;
    t_store_ctl         st_ctl;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= K_RST;
            r_ncls <= NCLS_RST;
            r_ofs  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_K:    r_k    <= i_cfg_data[K_W-1:0];
                CFG_NCLS: r_ncls <= i_cfg_data[NCLS_W-1:0];
                CFG_OFS:  r_ofs  <= i_cfg_data[LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_cls = (CMP_W'(r_ncls) > CMP_W'(MAX_CLASSES)) ? CMP_W'(MAX_CLASSES)
                                                          : CMP_W'(r_ncls);
        if (r_k == '0) begin
            eff_k = KCMP_W'(1);
        end else if (KCMP_W'(r_k) > KCMP_W'(MAX_NEIGHBOURS)) begin
            eff_k = KCMP_W'(MAX_NEIGHBOURS);
        end else begin
            eff_k = KCMP_W'(r_k);
        end
    end

    // handshake
    assign s1_adv     = r_s1_vld && (!r_o_vld || o_res.ready);
    assign i_nb.ready = !r_s1_vld || !r_o_vld || o_res.ready;
    assign acc        = i_nb.valid && i_nb.ready;
    assign in_range   = CMP_W'(i_nb.neighbour_class) < eff_cls;

    // stage 1: count read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cls <= ADDR_W'(i_nb.neighbour_class);
            r_s1_err <= !in_range;
        end
    end

    assign st_ctl.rd_en = acc && in_range;
    assign st_ctl.wr_en = s1_adv && !r_s1_err;
    assign st_ctl.clr   = s1_adv && last;

    kimv_count_store #(
        .DEPTH  (MAX_CLASSES),
        .DATA_W (CNT_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (st_ctl),
        .i_rd_addr (ADDR_W'(i_nb.neighbour_class)),
        .i_wr_addr (r_s1_cls),
        .i_wr_data (cnt_new),
        .o_count   (old_cnt)
    );

    // stage 2: increment, leader update
    always_comb begin
        cnt_new    = old_cnt + CNT_W'(1);
        take       = !r_s1_err && ((cnt_new > r_lead_cnt) ||
                     ((cnt_new == r_lead_cnt) && (r_s1_cls < r_lead_cls)));
        n_lead_cls = take ? r_s1_cls : r_lead_cls;
        n_lead_cnt = take ? cnt_new  : r_lead_cnt;
        n_seen     = r_seen + CNT_W'(1);
        last       = KCMP_W'(n_seen) >= eff_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_lead_cls <= '0;
            r_lead_cnt <= '0;
        end else if (s1_adv) begin
            if (last) begin
                r_seen     <= '0;
                r_lead_cls <= '0;
                r_lead_cnt <= '0;
            end else begin
                r_seen     <= n_seen;
                r_lead_cls <= n_lead_cls;
                r_lead_cnt <= n_lead_cnt;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_label <= r_ofs + LABEL_W'(n_lead_cls);
            r_o_last  <= last;
            r_o_err   <= r_s1_err;
        end
    end

    assign o_res.valid         = r_o_vld;
    assign o_res.class_label   = $signed(r_o_label);
    assign o_res.last_of_query = r_o_last;
    assign o_res.class_error   = r_o_err;

    `KIMV_ASSERT(a_lead_le_seen, i_clk, i_rst_n, r_lead_cnt <= r_seen)
    `KIMV_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, s1_adv && last,
                      (r_seen == '0) && (r_lead_cnt == '0) && (r_lead_cls == '0))
    `KIMV_ASSERT_NEXT(a_err_keeps_lead, i_clk, i_rst_n, s1_adv && r_s1_err && !last,
                      $stable(r_lead_cls) && $stable(r_lead_cnt))

endmodule

`default_nettype wire
